### src/bcpu_pkg.sv
package bcpu_pkg;

    // Command codes
    typedef enum logic [4:0] {
        CMD_OR       = 5'd0,
        CMD_AND      = 5'd1,
        CMD_XOR      = 5'd2,
        CMD_ADC      = 5'd3,
        CMD_SBC      = 5'd4,
        CMD_CMP      = 5'd5,
        CMD_INC      = 5'd6,
        CMD_DEC      = 5'd7,
        CMD_ASL      = 5'd8,
        CMD_ROL      = 5'd9,
        CMD_LSR      = 5'd10,
        CMD_ROR      = 5'd11,
        CMD_BIT      = 5'd12,
        CMD_LOAD     = 5'd13,
        CMD_READ     = 5'd14,
        CMD_TXS      = 5'd15,
        CMD_SETFLAG  = 5'd16,
        CMD_BRANCH   = 5'd17,
        CMD_PULL     = 5'd18,
        CMD_PUSH     = 5'd19,
        CMD_TRANSFER = 5'd20
    } cmd_t;

    // Register select codes; anything above SEL_SP means the operand byte
    localparam logic [2:0] SEL_A  = 3'd0;
    localparam logic [2:0] SEL_X  = 3'd1;
    localparam logic [2:0] SEL_Y  = 3'd2;
    localparam logic [2:0] SEL_SP = 3'd3;

    // Status bit positions, NV-BDIZC
    localparam logic [2:0] FLAG_C = 3'd0;
    localparam logic [2:0] FLAG_Z = 3'd1;
    localparam logic [2:0] FLAG_I = 3'd2;
    localparam logic [2:0] FLAG_D = 3'd3;
    localparam logic [2:0] FLAG_B = 3'd4;
    localparam logic [2:0] FLAG_R = 3'd5;
    localparam logic [2:0] FLAG_V = 3'd6;
    localparam logic [2:0] FLAG_N = 3'd7;

    localparam logic [7:0] STATUS_RESET = 8'h20;
    localparam logic [7:0] STATUS_RB    = 8'h30;

    // BCD adjust constants
    localparam logic [4:0] BCD_DIGIT_MAX = 5'd9;
    localparam logic [4:0] BCD_ADJUST    = 5'd6;
    localparam logic [5:0] NIBBLE_MAX    = 6'd15;

endpackage

### src/bcpu_if.sv
// Command channel: one instruction's execute request
interface bcpu_cmd_if;
    logic       valid;
    logic       ready;
    logic [4:0] command;
    logic [2:0] target_register;
    logic [1:0] source_register;
    logic [7:0] operand_byte;
    logic [2:0] flag_index;
    logic       flag_value;

    modport source (
        output valid, command, target_register, source_register,
               operand_byte, flag_index, flag_value,
        input  ready
    );
    modport sink (
        input  valid, command, target_register, source_register,
               operand_byte, flag_index, flag_value,
        output ready
    );
endinterface

// Result channel: one result item per instruction
interface bcpu_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] result_byte;
    logic       write_back;
    logic [7:0] status_out;
    logic       branch_taken;
    logic [7:0] accumulator_out;

    modport source (
        output valid, result_byte, write_back, status_out, branch_taken,
               accumulator_out,
        input  ready
    );
    modport sink (
        input  valid, result_byte, write_back, status_out, branch_taken,
               accumulator_out,
        output ready
    );
endinterface

### src/byte_cpu_execute_alu_unit.sv
// Execute stage of an 8-bit accumulator CPU holding A, X, Y, SP and the
// NV-BDIZC status byte. Each item on cmd carries a command and an already
// fetched operand byte; exactly one item comes back on rsp with the store
// byte (and its write-back strobe), the status, the branch decision and A.
// Throughput is one item per clock while rsp does not stall: an item is
// captured in an input register, executed by single-level ALU logic that
// updates the architectural registers, and lands in the result register,
// which drives rsp.valid. The register-file feedback closes within the
// execute step, so dependent items may follow back to back. With D set,
// ADC and SBC apply per-nibble BCD adjustment. rsp stalls hold the result
// register and back up into cmd.
module byte_cpu_execute_alu_unit
(
    input  logic              clk,
    input  logic              rst_n,
    bcpu_cmd_if.sink          cmd,
    bcpu_rsp_if.source        rsp
);

    // Input register
    logic       in_valid_reg;
    logic [4:0] cmd_reg;
    logic [2:0] tgt_reg;
    logic [1:0] src_reg;
    logic [7:0] op_reg;
    logic [2:0] fidx_reg;
    logic       fval_reg;

    // Architectural state
    logic [7:0] acc_reg, acc_next;
    logic [7:0] x_reg, x_next;
    logic [7:0] y_reg, y_next;
    logic [7:0] sp_reg, sp_next;
    logic [7:0] p_reg, p_next;

    // Result register
    logic       out_valid_reg;
    logic [7:0] res_reg, res_next;
    logic       wb_reg, wb_next;
    logic       taken_reg, taken_next;

    logic advance;
    logic execute;
    logic cin;

    // Binary adder
    logic [7:0] add_opnd;
    logic [8:0] bin_sum;
    logic [7:0] bin_r;
    logic       bin_v;

    // BCD add
    logic [4:0] dlo0;
    logic [4:0] dhi0;
    logic [5:0] dlo1;
    logic [4:0] dhi1;
    logic [5:0] dhi2;
    logic       dmsb;
    logic [7:0] dadd_r;

    // BCD subtract
    logic [4:0] slo0;
    logic [4:0] slo1;
    logic [4:0] shi0;
    logic [4:0] shi1;
    logic       sborrow;
    logic [7:0] dsub_r;

    // Common destination write
    logic       place_en;
    logic [7:0] place_val;
    logic [7:0] tgt_val;
    logic [7:0] src_val;
    logic [7:0] alu_v;
    logic [7:0] cmp_diff;

    function automatic logic [7:0] pick(
        input logic [2:0] sel,
        input logic [7:0] a,
        input logic [7:0] x,
        input logic [7:0] y,
        input logic [7:0] sp,
        input logic [7:0] opnd
    );
        logic [7:0] v;
        case (sel)
            bcpu_pkg::SEL_A:  v = a;
            bcpu_pkg::SEL_X:  v = x;
            bcpu_pkg::SEL_Y:  v = y;
            bcpu_pkg::SEL_SP: v = sp;
            default:          v = opnd;
        endcase
        return v;
    endfunction

    // Handshake: execute moves input register into result register
    assign advance   = !out_valid_reg || rsp.ready;
    assign execute   = in_valid_reg && advance;
    assign cmd.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg  <= cmd.command;
            tgt_reg  <= cmd.target_register;
            src_reg  <= cmd.source_register;
            op_reg   <= cmd.operand_byte;
            fidx_reg <= cmd.flag_index;
            fval_reg <= cmd.flag_value;
        end
    end

    assign cin = p_reg[bcpu_pkg::FLAG_C];

    // Binary add; SBC adds the inverted operand
    assign add_opnd = (cmd_reg == bcpu_pkg::CMD_SBC) ? ~op_reg : op_reg;
    assign bin_sum  = {1'b0, acc_reg} + {1'b0, add_opnd} + {8'd0, cin};
    assign bin_r    = bin_sum[7:0];
    assign bin_v    = ~(acc_reg[7] ^ add_opnd[7]) & (bin_r[7] ^ add_opnd[7]);

    // Decimal add, nibble adjust
    assign dlo0   = {1'b0, acc_reg[3:0]} + {1'b0, op_reg[3:0]} + {4'd0, cin};
    assign dhi0   = {1'b0, acc_reg[7:4]} + {1'b0, op_reg[7:4]};
    assign dlo1   = (dlo0 > bcpu_pkg::BCD_DIGIT_MAX) ? ({1'b0, dlo0} + {1'b0, bcpu_pkg::BCD_ADJUST})
                                                     : {1'b0, dlo0};
    assign dhi1   = dhi0 + {4'd0, (dlo1 > bcpu_pkg::NIBBLE_MAX)};
    assign dmsb   = dhi1[3];
    assign dhi2   = (dhi1 > bcpu_pkg::BCD_DIGIT_MAX) ? ({1'b0, dhi1} + {1'b0, bcpu_pkg::BCD_ADJUST})
                                                     : {1'b0, dhi1};
    assign dadd_r = {dhi2[3:0], dlo1[3:0]};

    // Decimal subtract; a negative nibble borrows and takes 6 off
    assign slo0    = {1'b0, acc_reg[3:0]} - {1'b0, op_reg[3:0]} - {4'd0, ~cin};
    assign sborrow = slo0[4];
    assign slo1    = sborrow ? (slo0 - bcpu_pkg::BCD_ADJUST) : slo0;
    assign shi0    = {1'b0, acc_reg[7:4]} - {1'b0, op_reg[7:4]} - {4'd0, sborrow};
    assign shi1    = shi0[4] ? (shi0 - bcpu_pkg::BCD_ADJUST) : shi0;
    assign dsub_r  = {shi1[3:0], slo1[3:0]};

    assign tgt_val  = pick(tgt_reg, acc_reg, x_reg, y_reg, sp_reg, op_reg);
    assign src_val  = pick({1'b0, src_reg}, acc_reg, x_reg, y_reg, sp_reg, op_reg);
    assign cmp_diff = tgt_val - op_reg;

    // Execute one command
    always_comb
    begin
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        sp_next    = sp_reg;
        p_next     = p_reg;
        res_next   = 8'd0;
        wb_next    = 1'b0;
        taken_next = 1'b0;
        place_en   = 1'b0;
        place_val  = tgt_val;
        alu_v      = tgt_val;

        case (cmd_reg)
            bcpu_pkg::CMD_OR, bcpu_pkg::CMD_AND, bcpu_pkg::CMD_XOR:
            begin
                if (cmd_reg == bcpu_pkg::CMD_OR)
                    acc_next = acc_reg | op_reg;
                else if (cmd_reg == bcpu_pkg::CMD_AND)
                    acc_next = acc_reg & op_reg;
                else
                    acc_next = acc_reg ^ op_reg;
                p_next[bcpu_pkg::FLAG_N] = acc_next[7];
                p_next[bcpu_pkg::FLAG_Z] = (acc_next == 8'd0);
            end
            bcpu_pkg::CMD_ADC:
            begin
                if (p_reg[bcpu_pkg::FLAG_D])
                begin
                    acc_next = dadd_r;
                    p_next[bcpu_pkg::FLAG_Z] = ((dlo0[3:0] | dhi0[3:0]) == 4'd0);
                    p_next[bcpu_pkg::FLAG_N] = dmsb;
                    p_next[bcpu_pkg::FLAG_V] = ~(acc_reg[7] ^ op_reg[7]) & (dmsb ^ op_reg[7]);
                    p_next[bcpu_pkg::FLAG_C] = (dhi2 > bcpu_pkg::NIBBLE_MAX);
                end
                else
                begin
                    acc_next = bin_r;
                    p_next[bcpu_pkg::FLAG_N] = bin_r[7];
                    p_next[bcpu_pkg::FLAG_Z] = (bin_r == 8'd0);
                    p_next[bcpu_pkg::FLAG_C] = bin_sum[8];
                    p_next[bcpu_pkg::FLAG_V] = bin_v;
                end
            end
            bcpu_pkg::CMD_SBC:
            begin
                // flags always come from the binary subtract
                acc_next = p_reg[bcpu_pkg::FLAG_D] ? dsub_r : bin_r;
                p_next[bcpu_pkg::FLAG_N] = bin_r[7];
                p_next[bcpu_pkg::FLAG_Z] = (bin_r == 8'd0);
                p_next[bcpu_pkg::FLAG_C] = bin_sum[8];
                p_next[bcpu_pkg::FLAG_V] = bin_v;
            end
            bcpu_pkg::CMD_CMP:
            begin
                p_next[bcpu_pkg::FLAG_N] = cmp_diff[7];
                p_next[bcpu_pkg::FLAG_Z] = (cmp_diff == 8'd0);
                p_next[bcpu_pkg::FLAG_C] = (tgt_val >= op_reg);
            end
            bcpu_pkg::CMD_INC, bcpu_pkg::CMD_DEC, bcpu_pkg::CMD_ASL,
            bcpu_pkg::CMD_ROL, bcpu_pkg::CMD_LSR, bcpu_pkg::CMD_ROR:
            begin
                case (cmd_reg)
                    bcpu_pkg::CMD_INC: alu_v = tgt_val + 8'd1;
                    bcpu_pkg::CMD_DEC: alu_v = tgt_val - 8'd1;
                    bcpu_pkg::CMD_ASL:
                    begin
                        p_next[bcpu_pkg::FLAG_C] = tgt_val[7];
                        alu_v = {tgt_val[6:0], 1'b0};
                    end
                    bcpu_pkg::CMD_ROL:
                    begin
                        p_next[bcpu_pkg::FLAG_C] = tgt_val[7];
                        alu_v = {tgt_val[6:0], cin};
                    end
                    bcpu_pkg::CMD_LSR:
                    begin
                        p_next[bcpu_pkg::FLAG_C] = tgt_val[0];
                        alu_v = {1'b0, tgt_val[7:1]};
                    end
                    default:
                    begin
                        p_next[bcpu_pkg::FLAG_C] = tgt_val[0];
                        alu_v = {cin, tgt_val[7:1]};
                    end
                endcase
                p_next[bcpu_pkg::FLAG_N] = alu_v[7];
                p_next[bcpu_pkg::FLAG_Z] = (alu_v == 8'd0);
                place_en  = 1'b1;
                place_val = alu_v;
            end
            bcpu_pkg::CMD_BIT:
            begin
                p_next[bcpu_pkg::FLAG_N] = op_reg[7];
                p_next[bcpu_pkg::FLAG_V] = op_reg[6];
                p_next[bcpu_pkg::FLAG_Z] = ((acc_reg & op_reg) == 8'd0);
            end
            bcpu_pkg::CMD_LOAD:
            begin
                // load into the operand byte does nothing
                if (tgt_reg <= bcpu_pkg::SEL_SP)
                begin
                    place_en  = 1'b1;
                    place_val = op_reg;
                    p_next[bcpu_pkg::FLAG_N] = op_reg[7];
                    p_next[bcpu_pkg::FLAG_Z] = (op_reg == 8'd0);
                end
            end
            bcpu_pkg::CMD_READ:
            begin
                res_next = tgt_val;
                wb_next  = 1'b1;
            end
            bcpu_pkg::CMD_TXS:
            begin
                sp_next = x_reg;
            end
            bcpu_pkg::CMD_SETFLAG:
            begin
                if (fidx_reg != bcpu_pkg::FLAG_R)
                    p_next[fidx_reg] = fval_reg;
            end
            bcpu_pkg::CMD_BRANCH:
            begin
                taken_next = (p_reg[fidx_reg] == fval_reg);
            end
            bcpu_pkg::CMD_PULL:
            begin
                p_next  = (op_reg & ~bcpu_pkg::STATUS_RB) | (p_reg & bcpu_pkg::STATUS_RB);
                sp_next = sp_reg + 8'd1;
            end
            bcpu_pkg::CMD_PUSH:
            begin
                res_next = p_reg | bcpu_pkg::STATUS_RB;
                wb_next  = 1'b1;
                sp_next  = sp_reg - 8'd1;
            end
            bcpu_pkg::CMD_TRANSFER:
            begin
                place_en  = 1'b1;
                place_val = src_val;
                // no N/Z update when SP or the operand byte is the target
                if (tgt_reg < bcpu_pkg::SEL_SP)
                begin
                    p_next[bcpu_pkg::FLAG_N] = src_val[7];
                    p_next[bcpu_pkg::FLAG_Z] = (src_val == 8'd0);
                end
            end
            default:
            begin
                p_next = p_reg;
            end
        endcase

        // Destination write: a register, or the operand byte for write-back
        if (place_en)
        begin
            case (tgt_reg)
                bcpu_pkg::SEL_A:  acc_next = place_val;
                bcpu_pkg::SEL_X:  x_next   = place_val;
                bcpu_pkg::SEL_Y:  y_next   = place_val;
                bcpu_pkg::SEL_SP: sp_next  = place_val;
                default:
                begin
                    res_next = place_val;
                    wb_next  = 1'b1;
                end
            endcase
        end

        p_next[bcpu_pkg::FLAG_R] = 1'b1;
    end

    // Architectural registers update once per executed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 8'd0;
            x_reg   <= 8'd0;
            y_reg   <= 8'd0;
            sp_reg  <= 8'd0;
            p_reg   <= bcpu_pkg::STATUS_RESET;
        end
        else if (execute)
        begin
            acc_reg <= acc_next;
            x_reg   <= x_next;
            y_reg   <= y_next;
            sp_reg  <= sp_next;
            p_reg   <= p_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (execute)
        begin
            res_reg   <= res_next;
            wb_reg    <= wb_next;
            taken_reg <= taken_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.result_byte     = res_reg;
    assign rsp.write_back      = wb_reg;
    assign rsp.status_out      = p_reg;
    assign rsp.branch_taken    = taken_reg;
    assign rsp.accumulator_out = acc_reg;

`ifndef SYNTHESIS
    // Reserved status bit never clears
    a_reserved_set: assert property (@(posedge clk) disable iff (!rst_n)
        p_reg[bcpu_pkg::FLAG_R])
        else $error("reserved status bit cleared");

    // Store byte reads zero unless written back
    a_res_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !wb_reg |-> res_reg == 8'd0)
        else $error("result byte nonzero without write-back");

    // State moves only when an item executes
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !execute |=> $stable(acc_reg) && $stable(x_reg) && $stable(y_reg)
                     && $stable(sp_reg) && $stable(p_reg))
        else $error("architectural state changed without an item");

    // Only a branch item can report a taken branch
    a_taken_branch: assert property (@(posedge clk) disable iff (!rst_n)
        execute && cmd_reg != bcpu_pkg::CMD_BRANCH |=> !taken_reg)
        else $error("branch taken on a non-branch command");

    // A pending result never sees a later state update
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> out_valid_reg && $stable(acc_reg) && $stable(p_reg))
        else $error("state advanced while result stalled");
`endif

endmodule
